// ----- src/pstc_pkg.sv -----
// shared types and codes for the prescaled step timer
package pstc_pkg;

   // width of the timer count and compare registers
   localparam int TIME_W = 64;
   // width of one bus word
   localparam int WORD_W = 32;

   // item kinds
   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   // bus register selectors
   typedef enum logic [2:0] {
      SEL_COUNT_LO   = 3'd0,
      SEL_COUNT_HI   = 3'd1,
      SEL_COMPARE_LO = 3'd2,
      SEL_COMPARE_HI = 3'd3,
      SEL_IRQ_STATE  = 3'd4
   } sel_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_PRESCALE   = 2'd0,
      CSR_STEP       = 2'd1,
      CSR_TIMER_EN   = 2'd2,
      CSR_IRQ_EN     = 2'd3
   } csr_index_type;

endpackage

// ----- src/prescaled_step_timer_with_compare.sv -----
// machine timer with prescaler, step increment and 64-bit compare
//
// Input channel (req_*): one item per transfer. kind selects a clock tick, a
// bus register write or a bus register read; reg_select picks count low/high,
// compare low/high or the interrupt state; write_data carries write values.
// Result channel (rsp_*): exactly one result per item, in order. read_data
// holds the selected register on reads and zero otherwise; irq is the pending
// bit AND the interrupt enable after the item took effect.
// Configuration port (csr_*): prescale, step, timer enable and interrupt
// enable, written while the block is idle.
// An item is held in the item register and processed from there; its result
// is registered in the result register before it can transfer. Throughput:
// one item per cycle while rsp_stall is low, set by the combinational 64-bit
// count add and count/compare magnitude check between the two registers.
// Reset clears count, divider and pending bit, sets compare to all ones,
// prescale to zero, step to one and both enables to zero.
// While rsp_stall holds, the waiting result stays put; one more item may be
// taken into the item register, after which req_stall rises.
module prescaled_step_timer_with_compare #(
   parameter int PRESCALE_BITS = 12,
   parameter int STEP_BITS     = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // item channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [1:0]                             req_kind,
   input  logic [2:0]                             req_reg_select,
   input  logic [pstc_pkg::WORD_W-1:0]            req_write_data,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [pstc_pkg::WORD_W-1:0]            rsp_read_data,
   output logic                                   rsp_irq,
   // configuration port
   input  logic                                   csr_write_enable,
   input  logic [1:0]                             csr_index,
   input  logic [((PRESCALE_BITS > STEP_BITS) ? PRESCALE_BITS : STEP_BITS)-1:0]
                                                  csr_write_data
);
   import pstc_pkg::*;

   // configuration registers
   logic [PRESCALE_BITS-1:0] prescale_ff;
   logic [STEP_BITS-1:0]     step_ff;
   logic                     timer_en_ff;
   logic                     irq_en_ff;

   // timer state
   logic [PRESCALE_BITS-1:0] divider_ff, divider_in;
   logic [TIME_W-1:0]        count_ff, count_in;
   logic [TIME_W-1:0]        compare_ff, compare_in;
   logic                     pending_ff, pending_in;
   logic                     pending_kept;

   // item register
   logic                     stage_valid_ff, stage_valid_in;
   logic [1:0]               kind_ff;
   logic [2:0]               sel_ff;
   logic [WORD_W-1:0]        wdata_ff;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]        rdata_ff, rdata_in;
   logic                     irq_ff, irq_in;

   logic                     stage_adv;
   logic                     req_accept;

   // handshake control
   assign stage_adv  = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = stage_valid_ff && !stage_adv;
   assign req_accept = req_valid && !req_stall;

   assign stage_valid_in = req_accept ? 1'b1 : (stage_adv ? 1'b0 : stage_valid_ff);
   assign rsp_valid_in   = stage_adv ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prescale_ff <= '0;
         step_ff     <= STEP_BITS'(1);
         timer_en_ff <= 1'b0;
         irq_en_ff   <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PRESCALE: prescale_ff <= csr_write_data[PRESCALE_BITS-1:0];
            CSR_STEP:     step_ff     <= csr_write_data[STEP_BITS-1:0];
            CSR_TIMER_EN: timer_en_ff <= csr_write_data[0];
            CSR_IRQ_EN:   irq_en_ff   <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // item processing: state update and result
   always_comb begin
      divider_in   = divider_ff;
      count_in     = count_ff;
      compare_in   = compare_ff;
      pending_kept = pending_ff;
      rdata_in     = '0;
      case (kind_type'(kind_ff))
         KIND_TICK: begin
            if (timer_en_ff) begin
               if (divider_ff >= prescale_ff) begin
                  divider_in = '0;
                  count_in   = count_ff + {{(TIME_W-STEP_BITS){1'b0}}, step_ff};
               end else begin
                  divider_in = divider_ff + PRESCALE_BITS'(1);
               end
            end
         end
         KIND_WRITE: begin
            unique case (sel_type'(sel_ff))
               SEL_COUNT_LO:   count_in   = {count_ff[TIME_W-1:WORD_W], wdata_ff};
               SEL_COUNT_HI:   count_in   = {wdata_ff, count_ff[WORD_W-1:0]};
               SEL_COMPARE_LO: compare_in = {compare_ff[TIME_W-1:WORD_W], wdata_ff};
               SEL_COMPARE_HI: compare_in = {wdata_ff, compare_ff[WORD_W-1:0]};
               SEL_IRQ_STATE:  if (wdata_ff[0]) pending_kept = 1'b0;
               default: ;
            endcase
         end
         KIND_READ: begin
            unique case (sel_type'(sel_ff))
               SEL_COUNT_LO:   rdata_in = count_ff[WORD_W-1:0];
               SEL_COUNT_HI:   rdata_in = count_ff[TIME_W-1:WORD_W];
               SEL_COMPARE_LO: rdata_in = compare_ff[WORD_W-1:0];
               SEL_COMPARE_HI: rdata_in = compare_ff[TIME_W-1:WORD_W];
               SEL_IRQ_STATE:  rdata_in = {{(WORD_W-1){1'b0}}, pending_ff};
               default: ;
            endcase
         end
         default: ;
      endcase
      // pending is raised again while count has reached compare
      pending_in = pending_kept || (count_in >= compare_in);
      irq_in     = pending_in && irq_en_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         divider_ff     <= '0;
         count_ff       <= '0;
         compare_ff     <= '1;
         pending_ff     <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (stage_adv) begin
            divider_ff <= divider_in;
            count_ff   <= count_in;
            compare_ff <= compare_in;
            pending_ff <= pending_in;
         end
      end
   end

   // item and result payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff  <= req_kind;
         sel_ff   <= req_reg_select;
         wdata_ff <= req_write_data;
      end
      if (stage_adv) begin
         rdata_ff <= rdata_in;
         irq_ff   <= irq_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rdata_ff;
   assign rsp_irq       = irq_ff;

`ifndef SYNTHESIS
   // pending always covers a count that has reached compare
   assert property (@(posedge clock) disable iff (reset)
      (count_ff >= compare_ff) |-> pending_ff)
      else $error("count reached compare without pending interrupt");

   // timer state only moves when an item is processed
   assert property (@(posedge clock) disable iff (reset)
      !stage_adv |=> ($stable(count_ff) && $stable(compare_ff) && $stable(divider_ff)))
      else $error("timer state changed without an item");

   // input stalls only with both item and result registers occupied
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (stage_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled with room available");

   // state after reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> (count_ff == '0 && compare_ff == '1 && !pending_ff))
      else $error("timer state wrong after reset");
`endif

endmodule
